[hdl/rsfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfp_pkg: shared types and constants for the frame header parser
// Holds the frame length width, byte class codes, register indexes and the
// structs that carry the parser state, configuration and per-byte result.
// ----------------------------------------------------------------------------
package rsfp_pkg;

  localparam int LEN_BITS  = 24;  // width of the saturating byte counter
  localparam int FLEN_BITS = 24;  // width of reported lengths
  // compare width that holds any count or length plus headroom
  localparam int CMP_BITS  = ((LEN_BITS > FLEN_BITS) ? LEN_BITS : FLEN_BITS) + 2;

  localparam int HDR_STREAM_BYTES = 4;
  localparam int HDR_BYTES        = 6;
  localparam int MLEN_BYTES       = 3;
  localparam int POS_BYTES        = 8;
  localparam int ERR_BYTES        = 4;

  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_META_LEN = 3'd1;
  localparam logic [2:0] KIND_METADATA = 3'd2;
  localparam logic [2:0] KIND_DATA     = 3'd3;
  localparam logic [2:0] KIND_POSITION = 3'd4;
  localparam logic [2:0] KIND_ERR_CODE = 3'd5;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 10;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEPALIVE_CODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAYLOAD_CODE   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_REQ_RESP_CODE  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ERROR_CODE     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_META_FLAG_MASK = 3'd4;

  typedef struct packed {
    logic [5:0] keepalive_code;
    logic [5:0] payload_code;
    logic [5:0] req_resp_code;
    logic [5:0] error_code;
    logic [9:0] meta_flag_mask;
  } cfg_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]  byte_count;
    logic [31:0]          stream;
    logic [15:0]          type_flags;
    logic [FLEN_BITS-1:0] meta_len;
    logic [63:0]          position;
  } state_t;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic [2:0]           byte_kind;
    logic                 frame_end;
    logic                 frame_ok;
    logic [31:0]          stream_id;
    logic [5:0]           frame_type;
    logic [9:0]           flag_bits;
    logic                 metadata_present;
    logic [FLEN_BITS-1:0] metadata_len;
    logic [FLEN_BITS-1:0] data_len;
    logic [63:0]          keepalive_position;
  } result_t;

endpackage
`default_nettype wire

[hdl/rsfp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfp_in_if / rsfp_out_if: valid/ready channels of the frame header parser
// The input channel carries raw frame bytes; the output channel carries the
// classified byte and the frame report.
// ----------------------------------------------------------------------------
interface rsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface rsfp_out_if;
  import rsfp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [7:0]           data_byte;
  logic [2:0]           byte_kind;
  logic                 frame_end;
  logic                 frame_ok;
  logic [31:0]          stream_id;
  logic [5:0]           frame_type;
  logic [9:0]           flag_bits;
  logic                 metadata_present;
  logic [FLEN_BITS-1:0] metadata_len;
  logic [FLEN_BITS-1:0] data_len;
  logic [63:0]          keepalive_position;

  modport source (output valid, output data_byte, output byte_kind, output frame_end,
                  output frame_ok, output stream_id, output frame_type, output flag_bits,
                  output metadata_present, output metadata_len, output data_len,
                  output keepalive_position, input ready);
  modport sink   (input valid, input data_byte, input byte_kind, input frame_end,
                  input frame_ok, input stream_id, input frame_type, input flag_bits,
                  input metadata_present, input metadata_len, input data_len,
                  input keepalive_position, output ready);
endinterface
`default_nettype wire

[hdl/rsfp_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsfp_decode: per-byte classification and frame report logic
// Combinational next state and result for one frame byte, given the current
// header capture state and the type code configuration.
// ----------------------------------------------------------------------------
module rsfp_decode (
  input  rsfp_pkg::state_t  st_i,
  input  rsfp_pkg::cfg_t    cfg_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  output rsfp_pkg::state_t  st_o,
  output rsfp_pkg::result_t res_o
);
  import rsfp_pkg::*;

  logic [LEN_BITS-1:0] cnt;
  logic                oversize;
  logic [CMP_BITS-1:0] cnt_e;
  logic [CMP_BITS-1:0] off;
  logic [CMP_BITS-1:0] body;
  logic [CMP_BITS-1:0] meta_old_e;
  logic [CMP_BITS-1:0] meta_new_e;
  logic [CMP_BITS-1:0] dlen;
  logic [31:0]         stream_d;
  logic [15:0]         type_flags_d;
  logic [5:0]          ftype;
  logic [9:0]          flags;
  logic                is_ka;
  logic                is_pr;
  logic                is_err;
  logic                has_meta;
  logic                in_body;
  logic                ok;
  logic                mpres;
  logic [63:0]         pos;
  logic [2:0]          kind;
  state_t              nxt;

  assign cnt        = st_i.byte_count;
  assign oversize   = &cnt;
  assign cnt_e      = CMP_BITS'(cnt);
  assign off        = cnt_e - CMP_BITS'(HDR_BYTES);
  assign body       = cnt_e + CMP_BITS'(1) - CMP_BITS'(HDR_BYTES);
  assign meta_old_e = CMP_BITS'(st_i.meta_len);
  assign in_body    = (cnt >= LEN_BITS'(HDR_BYTES));

  assign stream_d     = (cnt < LEN_BITS'(HDR_STREAM_BYTES)) ?
                        {st_i.stream[23:0], byte_i} : st_i.stream;
  assign type_flags_d = (cnt >= LEN_BITS'(HDR_STREAM_BYTES) && !in_body) ?
                        {st_i.type_flags[7:0], byte_i} : st_i.type_flags;

  assign ftype    = type_flags_d[15:10];
  assign flags    = type_flags_d[9:0];
  assign is_ka    = (ftype == cfg_i.keepalive_code);
  assign is_pr    = !is_ka && (ftype == cfg_i.payload_code || ftype == cfg_i.req_resp_code);
  assign is_err   = !is_ka && !is_pr && (ftype == cfg_i.error_code);
  assign has_meta = |(flags & cfg_i.meta_flag_mask);

  // classify the byte and shift header and body fields into their capture registers
  always_comb begin
    nxt            = st_i;
    nxt.stream     = stream_d;
    nxt.type_flags = type_flags_d;
    kind           = KIND_HEADER;
    if (in_body) begin
      if (is_ka) begin
        if (off < CMP_BITS'(POS_BYTES)) begin
          kind         = KIND_POSITION;
          nxt.position = {st_i.position[55:0], byte_i};
        end else begin
          kind = KIND_DATA;
        end
      end else if (is_pr && has_meta) begin
        if (off < CMP_BITS'(MLEN_BYTES)) begin
          kind         = KIND_META_LEN;
          nxt.meta_len = {st_i.meta_len[FLEN_BITS-9:0], byte_i};
        end else if (off - CMP_BITS'(MLEN_BYTES) < meta_old_e) begin
          kind = KIND_METADATA;
        end else begin
          kind = KIND_DATA;
        end
      end else if (is_err) begin
        kind = (off < CMP_BITS'(ERR_BYTES)) ? KIND_ERR_CODE : KIND_DATA;
      end else begin
        kind = KIND_DATA;
      end
    end
  end

  assign meta_new_e = CMP_BITS'(nxt.meta_len);

  // frame report on the last byte
  always_comb begin
    ok    = !oversize && (cnt >= LEN_BITS'(HDR_BYTES - 1));
    mpres = 1'b0;
    dlen  = '0;
    pos   = '0;
    if (is_ka) begin
      if (body >= CMP_BITS'(POS_BYTES)) begin
        pos  = nxt.position;
        dlen = body - CMP_BITS'(POS_BYTES);
      end
    end else if (is_pr) begin
      if (has_meta) begin
        if (body < CMP_BITS'(MLEN_BYTES) || CMP_BITS'(MLEN_BYTES) + meta_new_e > body) begin
          ok = 1'b0;
        end else begin
          mpres = 1'b1;
          dlen  = body - CMP_BITS'(MLEN_BYTES) - meta_new_e;
        end
      end else begin
        dlen = body;
      end
    end else if (is_err) begin
      if (body >= CMP_BITS'(ERR_BYTES)) begin
        dlen = body - CMP_BITS'(ERR_BYTES);
      end
    end else begin
      dlen = body;
    end
  end

  always_comb begin
    res_o           = '0;
    res_o.data_byte = byte_i;
    res_o.byte_kind = kind;
    if (last_i) begin
      res_o.frame_end  = 1'b1;
      res_o.frame_ok   = ok;
      res_o.stream_id  = stream_d;
      res_o.frame_type = ftype;
      res_o.flag_bits  = flags;
      if (ok) begin
        res_o.metadata_present   = mpres;
        res_o.metadata_len       = mpres ? nxt.meta_len : '0;
        res_o.data_len           = dlen[FLEN_BITS-1:0];
        res_o.keepalive_position = pos;
      end
    end
  end

  // clear after the last byte; hold the count once saturated
  always_comb begin
    st_o = nxt;
    if (last_i) begin
      st_o = '0;
    end else if (!oversize) begin
      st_o.byte_count = cnt + LEN_BITS'(1);
    end
  end

endmodule
`default_nettype wire

[hdl/rsocket_frame_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each accepted byte's result is registered and shown on the output channel in the next cycle.
// Throughput: one byte per cycle; the single result register accepts a new
// byte whenever it is empty or its transaction completes in the same cycle.
// Reset: clears the frame capture state and the output valid, and loads the
// type code registers with their defaults (3, 10, 4, 11, mask 0x100).
// ----------------------------------------------------------------------------
// rsocket_frame_parser: byte-serial frame header parser
// Captures the header, classes each byte and reports the frame on its last byte.
// ----------------------------------------------------------------------------
module rsocket_frame_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rsfp_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [rsfp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  rsfp_in_if.sink                             in_i,
  rsfp_out_if.source                          out_o
);
  import rsfp_pkg::*;

  cfg_t    cfg_q;
  state_t  st_q;
  state_t  st_d;
  result_t res_q;
  result_t res_d;
  logic    valid_q;
  logic    accept;

  assign in_i.ready = !valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  rsfp_decode u_decode (
    .st_i   (st_q),
    .cfg_i  (cfg_q),
    .byte_i (in_i.byte_in),
    .last_i (in_i.last_byte),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keepalive_code <= 6'd3;
      cfg_q.payload_code   <= 6'd10;
      cfg_q.req_resp_code  <= 6'd4;
      cfg_q.error_code     <= 6'd11;
      cfg_q.meta_flag_mask <= 10'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEEPALIVE_CODE: cfg_q.keepalive_code <= cfg_wdata_i[5:0];
        REG_PAYLOAD_CODE:   cfg_q.payload_code   <= cfg_wdata_i[5:0];
        REG_REQ_RESP_CODE:  cfg_q.req_resp_code  <= cfg_wdata_i[5:0];
        REG_ERROR_CODE:     cfg_q.error_code     <= cfg_wdata_i[5:0];
        REG_META_FLAG_MASK: cfg_q.meta_flag_mask <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      valid_q <= 1'b0;
    end else if (accept) begin
      st_q    <= st_d;
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // hold the result until its transaction completes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = valid_q;
  assign out_o.data_byte          = res_q.data_byte;
  assign out_o.byte_kind          = res_q.byte_kind;
  assign out_o.frame_end          = res_q.frame_end;
  assign out_o.frame_ok           = res_q.frame_ok;
  assign out_o.stream_id          = res_q.stream_id;
  assign out_o.frame_type         = res_q.frame_type;
  assign out_o.flag_bits          = res_q.flag_bits;
  assign out_o.metadata_present   = res_q.metadata_present;
  assign out_o.metadata_len       = res_q.metadata_len;
  assign out_o.data_len           = res_q.data_len;
  assign out_o.keepalive_position = res_q.keepalive_position;

endmodule
`default_nettype wire
